>>> rtl/core/lla_pkg.sv
// Shared types and constants for the lease lock arbiter core.
// Holds command, result and counter codes, the item and result structs, and owner checks.
// No dependencies.
package lla_pkg;

    // Command codes
    localparam logic [3:0] CMD_RESET        = 4'd0;
    localparam logic [3:0] CMD_REQUEST      = 4'd1;
    localparam logic [3:0] CMD_RELEASE      = 4'd2;
    localparam logic [3:0] CMD_FORCE_CLEAR  = 4'd3;
    localparam logic [3:0] CMD_MODE_CHANGE  = 4'd4;
    localparam logic [3:0] CMD_REQ_INHIBIT  = 4'd5;
    localparam logic [3:0] CMD_REL_INHIBIT  = 4'd6;
    localparam logic [3:0] CMD_CLR_INHIBIT  = 4'd7;
    localparam logic [3:0] CMD_READ_COUNTER = 4'd8;

    // Result codes
    localparam logic [3:0] RES_GRANTED   = 4'd0;
    localparam logic [3:0] RES_ALREADY   = 4'd1;
    localparam logic [3:0] RES_RELEASED  = 4'd2;
    localparam logic [3:0] RES_BUSY      = 4'd3;
    localparam logic [3:0] RES_INHIBITED = 4'd4;
    localparam logic [3:0] RES_MODE      = 4'd5;
    localparam logic [3:0] RES_UNKNOWN   = 4'd6;
    localparam logic [3:0] RES_NOT_OWNER = 4'd7;
    localparam logic [3:0] RES_STALE     = 4'd8;
    localparam logic [3:0] RES_NOT_HELD  = 4'd9;
    localparam logic [3:0] RES_NONE      = 4'd10;

    // Event counter indexes
    localparam logic [2:0] CNT_GRANTS     = 3'd0;
    localparam logic [2:0] CNT_ALREADY    = 3'd1;
    localparam logic [2:0] CNT_RELEASES   = 3'd2;
    localparam logic [2:0] CNT_REJECTIONS = 3'd3;
    localparam logic [2:0] CNT_STALE      = 3'd4;
    localparam logic [2:0] CNT_INH_REJ    = 3'd5;
    localparam logic [2:0] CNT_FORCE      = 3'd6;
    localparam logic [2:0] CNT_INH_GRANTS = 3'd7;
    localparam int         NUM_COUNTERS   = 8;

    // Owner codes and limits
    localparam logic [2:0] OWNER_NONE   = 3'd0;
    localparam logic [2:0] MOTION_OWNER = 3'd5;
    localparam logic [3:0] OWNER_COUNT  = 4'd6;

    localparam logic       MODE_MAINT         = 1'b0;
    localparam logic [2:0] INHIBIT_FW_UPDATE  = 3'd1;
    localparam logic [2:0] CLEAR_MODE_CHANGED = 3'd3;

    localparam int ITEM_BITS   = 56;
    localparam int RESULT_BITS = 88;

    // Input item, first field in the low bits
    typedef struct packed {
        logic [6:0]  pad;
        logic [2:0]  counter_index;
        logic [2:0]  reason_code;
        logic [31:0] lease_generation;
        logic [2:0]  lease_owner;
        logic        mode;
        logic [2:0]  owner_code;
        logic [3:0]  command;
    } item_t;

    // Result item, first field in the low bits
    typedef struct packed {
        logic [4:0]  pad;
        logic [31:0] counter_value;
        logic [3:0]  last_outcome;
        logic [2:0]  last_clear;
        logic        inhibit_cause;
        logic        inhibit_active;
        logic [2:0]  current_owner;
        logic [31:0] granted_generation;
        logic [2:0]  granted_owner;
        logic [3:0]  result_code;
    } result_t;

    function automatic logic owner_known(input logic [2:0] owner);
        owner_known = (owner != OWNER_NONE) && ({1'b0, owner} < OWNER_COUNT);
    endfunction

    function automatic logic mode_fits(input logic mode, input logic [2:0] owner);
        logic fits;
        if ({1'b0, owner} >= OWNER_COUNT)
        begin
            fits = 1'b0;
        end
        else if (owner == OWNER_NONE)
        begin
            fits = 1'b1;
        end
        else if (mode == MODE_MAINT)
        begin
            fits = (owner != MOTION_OWNER);
        end
        else
        begin
            fits = (owner == MOTION_OWNER);
        end
        mode_fits = fits;
    endfunction

endpackage

>>> rtl/core/lla_in_stage.sv
// Input register of the lease lock arbiter core.
// Captures one command item per transfer; depends on lla_pkg.
module lla_in_stage
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [lla_pkg::ITEM_BITS-1:0] s_tdata,
    input  logic                         advance,
    output logic                         item_valid,
    output lla_pkg::item_t               item
);
    import lla_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  take;

    assign s_tready = !valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_t'(s_tdata);
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> rtl/core/lla_engine.sv
// Arbitration state and command evaluation for the lease lock arbiter core.
// Holds owner, generation, inhibit, history and event counters; depends on lla_pkg.
module lla_engine #(
    parameter int GEN_WIDTH   = 32,
    parameter int COUNT_WIDTH = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  lla_pkg::item_t   item,
    output lla_pkg::result_t result
);
    import lla_pkg::*;

    localparam int GW = (GEN_WIDTH > 32) ? GEN_WIDTH : 32;
    localparam int KW = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

    logic [2:0]           owner_reg,          owner_next;
    logic [GEN_WIDTH-1:0] generation_reg,     generation_next;
    logic [GEN_WIDTH-1:0] inhibit_gen_reg,    inhibit_gen_next;
    logic                 inhibit_reason_reg, inhibit_reason_next;
    logic [2:0]           last_clear_reg,     last_clear_next;
    logic [3:0]           last_result_reg,    last_result_next;
    logic [COUNT_WIDTH-1:0] counters_reg [NUM_COUNTERS];

    logic [NUM_COUNTERS-1:0] cnt_inc;
    logic                    cnt_clear;
    logic                    rec;
    logic [3:0]              res;
    logic [2:0]              g_owner;
    logic [GEN_WIDTH-1:0]    g_gen;
    logic [COUNT_WIDTH-1:0]  cval;

    logic [GEN_WIDTH-1:0] gen_inc;
    logic [GEN_WIDTH-1:0] gen_step;
    logic                 inhibit_on;
    logic [GW-1:0]        lgen_ext;
    logic [GW-1:0]        gen_ext;
    logic [GW-1:0]        inh_ext;
    logic [GW-1:0]        g_gen_ext;
    logic [KW-1:0]        cval_ext;

    // Next generation wraps and skips zero
    assign gen_inc    = generation_reg + 1'b1;
    assign gen_step   = (gen_inc == '0) ? GEN_WIDTH'(1) : gen_inc;
    assign inhibit_on = (inhibit_gen_reg != '0);
    assign lgen_ext   = GW'(item.lease_generation);
    assign gen_ext    = GW'(generation_reg);
    assign inh_ext    = GW'(inhibit_gen_reg);

    always_comb
    begin
        owner_next          = owner_reg;
        generation_next     = generation_reg;
        inhibit_gen_next    = inhibit_gen_reg;
        inhibit_reason_next = inhibit_reason_reg;
        last_clear_next     = last_clear_reg;
        last_result_next    = last_result_reg;
        cnt_inc             = '0;
        cnt_clear           = 1'b0;
        rec                 = 1'b0;
        res                 = RES_NONE;
        g_owner             = OWNER_NONE;
        g_gen               = '0;
        cval                = '0;

        case (item.command)
            CMD_RESET:
            begin
                owner_next          = OWNER_NONE;
                generation_next     = '0;
                inhibit_gen_next    = '0;
                inhibit_reason_next = 1'b0;
                last_clear_next     = item.reason_code;
                last_result_next    = RES_RELEASED;
                cnt_clear           = 1'b1;
            end
            CMD_REQUEST:
            begin
                rec = 1'b1;
                if (!owner_known(item.owner_code))
                begin
                    res = RES_UNKNOWN;
                end
                else if (inhibit_on)
                begin
                    cnt_inc[CNT_INH_REJ] = 1'b1;
                    res = RES_INHIBITED;
                end
                else if (!mode_fits(item.mode, item.owner_code))
                begin
                    res = RES_MODE;
                end
                else if (owner_reg == item.owner_code)
                begin
                    res = RES_ALREADY;
                end
                else if (owner_reg != OWNER_NONE)
                begin
                    res = RES_BUSY;
                end
                else
                begin
                    owner_next      = item.owner_code;
                    g_owner         = item.owner_code;
                    generation_next = gen_step;
                    g_gen           = gen_step;
                    res             = RES_GRANTED;
                end
            end
            CMD_RELEASE:
            begin
                rec = 1'b1;
                if (owner_reg == OWNER_NONE)
                begin
                    res = RES_NOT_HELD;
                end
                else if (item.lease_owner != owner_reg)
                begin
                    res = RES_NOT_OWNER;
                end
                else if (lgen_ext != gen_ext)
                begin
                    res = RES_STALE;
                end
                else
                begin
                    owner_next = OWNER_NONE;
                    res        = RES_RELEASED;
                end
            end
            CMD_FORCE_CLEAR:
            begin
                last_clear_next = item.reason_code;
                if (owner_reg != OWNER_NONE)
                begin
                    owner_next         = OWNER_NONE;
                    cnt_inc[CNT_FORCE] = 1'b1;
                    last_result_next   = RES_RELEASED;
                end
            end
            CMD_MODE_CHANGE:
            begin
                // Drop an owner that does not fit the new mode
                if (owner_reg != OWNER_NONE && !mode_fits(item.mode, owner_reg))
                begin
                    last_clear_next    = CLEAR_MODE_CHANGED;
                    owner_next         = OWNER_NONE;
                    cnt_inc[CNT_FORCE] = 1'b1;
                    last_result_next   = RES_RELEASED;
                end
            end
            CMD_REQ_INHIBIT:
            begin
                rec = 1'b1;
                if (item.reason_code != INHIBIT_FW_UPDATE)
                begin
                    cnt_inc[CNT_INH_REJ] = 1'b1;
                    res = RES_UNKNOWN;
                end
                else if (inhibit_on)
                begin
                    cnt_inc[CNT_INH_REJ] = 1'b1;
                    res = RES_INHIBITED;
                end
                else if (owner_reg != OWNER_NONE)
                begin
                    cnt_inc[CNT_INH_REJ] = 1'b1;
                    res = RES_BUSY;
                end
                else
                begin
                    generation_next         = gen_step;
                    inhibit_gen_next        = gen_step;
                    inhibit_reason_next     = 1'b1;
                    cnt_inc[CNT_INH_GRANTS] = 1'b1;
                    g_gen                   = gen_step;
                    res                     = RES_GRANTED;
                end
            end
            CMD_REL_INHIBIT:
            begin
                rec = 1'b1;
                if (!inhibit_on)
                begin
                    res = RES_NOT_HELD;
                end
                else if (lgen_ext != inh_ext)
                begin
                    res = RES_STALE;
                end
                else
                begin
                    inhibit_gen_next    = '0;
                    inhibit_reason_next = 1'b0;
                    res                 = RES_RELEASED;
                end
            end
            CMD_CLR_INHIBIT:
            begin
                if (inhibit_on)
                begin
                    inhibit_gen_next    = '0;
                    inhibit_reason_next = 1'b0;
                    cnt_inc[CNT_FORCE]  = 1'b1;
                end
            end
            CMD_READ_COUNTER:
            begin
                cval = counters_reg[item.counter_index];
            end
            default:
            begin
            end
        endcase

        // Record the outcome and count it
        if (rec)
        begin
            last_result_next = res;
            case (res)
                RES_GRANTED:  cnt_inc[CNT_GRANTS]   = 1'b1;
                RES_ALREADY:  cnt_inc[CNT_ALREADY]  = 1'b1;
                RES_RELEASED: cnt_inc[CNT_RELEASES] = 1'b1;
                default:
                begin
                    cnt_inc[CNT_REJECTIONS] = 1'b1;
                    if (res == RES_STALE)
                    begin
                        cnt_inc[CNT_STALE] = 1'b1;
                    end
                end
            endcase
        end
    end

    assign g_gen_ext = GW'(g_gen);
    assign cval_ext  = KW'(cval);

    always_comb
    begin
        result                    = '0;
        result.result_code        = res;
        result.granted_owner      = g_owner;
        result.granted_generation = g_gen_ext[31:0];
        result.current_owner      = owner_next;
        result.inhibit_active     = (inhibit_gen_next != '0);
        result.inhibit_cause      = inhibit_reason_next;
        result.last_clear         = last_clear_next;
        result.last_outcome       = last_result_next;
        result.counter_value      = cval_ext[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owner_reg          <= OWNER_NONE;
            generation_reg     <= '0;
            inhibit_gen_reg    <= '0;
            inhibit_reason_reg <= 1'b0;
            last_clear_reg     <= '0;
            last_result_reg    <= RES_RELEASED;
            for (int i = 0; i < NUM_COUNTERS; i++)
            begin
                counters_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            owner_reg          <= owner_next;
            generation_reg     <= generation_next;
            inhibit_gen_reg    <= inhibit_gen_next;
            inhibit_reason_reg <= inhibit_reason_next;
            last_clear_reg     <= last_clear_next;
            last_result_reg    <= last_result_next;
            for (int i = 0; i < NUM_COUNTERS; i++)
            begin
                if (cnt_clear)
                begin
                    counters_reg[i] <= '0;
                end
                else if (cnt_inc[i])
                begin
                    counters_reg[i] <= counters_reg[i] + 1'b1;
                end
            end
        end
    end

endmodule

>>> rtl/core/lla_out_stage.sv
// Result register of the lease lock arbiter core.
// Holds one result until the downstream transfer; depends on lla_pkg.
module lla_out_stage
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           load,
    input  lla_pkg::result_t               result,
    output logic                           space,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [lla_pkg::RESULT_BITS-1:0] m_tdata
);
    import lla_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign space = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = RESULT_BITS'(data_reg);

endmodule

>>> rtl/core/lease_lock_arbiter_core.sv
// Lease lock arbiter core: exclusive ownership with generation-numbered leases.
// Input register, command evaluation against the held state, result register.
// Uses the input stream one command per transfer and returns one result per command.
// A command accepted into the input register is evaluated there and its result is loaded
// into the result register, for m_tdata, once the result register is free.
// Throughput: one command per cycle while m_tready is high; the state update for one command
// is one pass through the evaluation logic between the input and result registers.
// Backpressure: while m_tready is low the result holds; the input register still
// takes one more command, after which s_tready drops until the result is taken.
// Reset (rst_n low): owner none, generation and inhibit zero, last clear zero,
// last outcome released, all event counters zero; both registers empty.
// A reset command clears the same state and records its reason as the last clear.
// Generations wrap at GEN_WIDTH bits and skip zero; event counters wrap at
// COUNT_WIDTH bits and show their low 32 bits on read.
module lease_lock_arbiter_core #(
    parameter int GEN_WIDTH   = 32,
    parameter int COUNT_WIDTH = 32
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // command, owner_code, mode, lease_owner, lease_generation, reason_code,
    // counter_index, zero pad
    input  logic [lla_pkg::ITEM_BITS-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // result_code, granted_owner, granted_generation, current_owner, inhibit_active,
    // inhibit_cause, last_clear, last_outcome, counter_value, zero pad
    output logic [lla_pkg::RESULT_BITS-1:0] m_tdata
);
    import lla_pkg::*;

    item_t   item;
    logic    item_valid;
    result_t result;
    logic    space;
    logic    advance;

    // Move the held command into the result register when it has room
    assign advance = item_valid && space;

    lla_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    lla_engine #(
        .GEN_WIDTH   (GEN_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_engine
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (item),
        .result (result)
    );

    lla_out_stage u_out_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .result   (result),
        .space    (space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

>>> tb/testbench.sv
// Self-checking testbench for lease_lock_arbiter_core.
// Drives commands on the slave stream, predicts each result from a local copy of the arbiter
// state and compares every master transfer field by field. Depends on lla_pkg and the core.
`timescale 1ns / 100ps

module testbench;

    import lla_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int MAX_PRINTED = 40;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [ITEM_BITS-1:0]   s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [RESULT_BITS-1:0] m_tdata;

    // predicted arbiter state
    logic [2:0]  owner_q;
    logic [31:0] gen_q;
    logic [31:0] inh_gen_q;
    logic        inh_cause_q;
    logic [2:0]  clear_q;
    logic [3:0]  outcome_q;
    logic [31:0] tally_q [NUM_COUNTERS];

    result_t verdict_q [$];
    bit      with_idle;
    int      commands_sent;
    int      results_checked;
    int      mismatches;
    int      lease_grants;
    int      inhibit_leases;

    lease_lock_arbiter_core dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void clear_state();
        owner_q     = OWNER_NONE;
        gen_q       = '0;
        inh_gen_q   = '0;
        inh_cause_q = 1'b0;
        clear_q     = '0;
        outcome_q   = RES_RELEASED;
        foreach (tally_q[i])
            tally_q[i] = '0;
    endfunction

    function automatic void count_event(logic [2:0] idx);
        tally_q[idx] = tally_q[idx] + 32'd1;
    endfunction

    // store the outcome and bump the counters it belongs to
    function automatic logic [3:0] log_outcome(logic [3:0] res);
        outcome_q = res;
        case (res)
            RES_GRANTED:  count_event(CNT_GRANTS);
            RES_ALREADY:  count_event(CNT_ALREADY);
            RES_RELEASED: count_event(CNT_RELEASES);
            default:
            begin
                if (res == RES_STALE)
                    count_event(CNT_STALE);
                count_event(CNT_REJECTIONS);
            end
        endcase
        return res;
    endfunction

    function automatic logic owner_fits_mode(logic run_mode, logic [2:0] who);
        if (who == OWNER_NONE)
            return 1'b1;
        if ({1'b0, who} >= OWNER_COUNT)
            return 1'b0;
        return (who == MOTION_OWNER) == (run_mode != MODE_MAINT);
    endfunction

    // generation zero means no lease, so skip it on wrap
    function automatic logic [31:0] draw_generation();
        gen_q = gen_q + 32'd1;
        if (gen_q == '0)
            gen_q = 32'd1;
        return gen_q;
    endfunction

    function automatic void drop_owner(logic [2:0] why);
        clear_q = why;
        if (owner_q != OWNER_NONE)
        begin
            owner_q   = OWNER_NONE;
            outcome_q = RES_RELEASED;
            count_event(CNT_FORCE);
        end
    endfunction

    function automatic result_t arbitrate_command(item_t it);
        result_t r;
        r = '0;
        r.result_code = RES_NONE;
        case (it.command)
            CMD_RESET:
            begin
                clear_state();
                clear_q = it.reason_code;
            end
            CMD_REQUEST:
            begin
                if (it.owner_code == OWNER_NONE || {1'b0, it.owner_code} >= OWNER_COUNT)
                    r.result_code = log_outcome(RES_UNKNOWN);
                else if (inh_gen_q != '0)
                begin
                    count_event(CNT_INH_REJ);
                    r.result_code = log_outcome(RES_INHIBITED);
                end
                else if (!owner_fits_mode(it.mode, it.owner_code))
                    r.result_code = log_outcome(RES_MODE);
                else if (owner_q == it.owner_code)
                    r.result_code = log_outcome(RES_ALREADY);
                else if (owner_q != OWNER_NONE)
                    r.result_code = log_outcome(RES_BUSY);
                else
                begin
                    owner_q              = it.owner_code;
                    r.granted_owner      = it.owner_code;
                    r.granted_generation = draw_generation();
                    r.result_code        = log_outcome(RES_GRANTED);
                    lease_grants++;
                end
            end
            CMD_RELEASE:
            begin
                if (owner_q == OWNER_NONE)
                    r.result_code = log_outcome(RES_NOT_HELD);
                else if (it.lease_owner != owner_q)
                    r.result_code = log_outcome(RES_NOT_OWNER);
                else if (it.lease_generation != gen_q)
                    r.result_code = log_outcome(RES_STALE);
                else
                begin
                    owner_q       = OWNER_NONE;
                    r.result_code = log_outcome(RES_RELEASED);
                end
            end
            CMD_FORCE_CLEAR:
                drop_owner(it.reason_code);
            CMD_MODE_CHANGE:
            begin
                if (owner_q != OWNER_NONE && !owner_fits_mode(it.mode, owner_q))
                    drop_owner(CLEAR_MODE_CHANGED);
            end
            CMD_REQ_INHIBIT:
            begin
                if (it.reason_code != INHIBIT_FW_UPDATE)
                begin
                    count_event(CNT_INH_REJ);
                    r.result_code = log_outcome(RES_UNKNOWN);
                end
                else if (inh_gen_q != '0)
                begin
                    count_event(CNT_INH_REJ);
                    r.result_code = log_outcome(RES_INHIBITED);
                end
                else if (owner_q != OWNER_NONE)
                begin
                    count_event(CNT_INH_REJ);
                    r.result_code = log_outcome(RES_BUSY);
                end
                else
                begin
                    inh_gen_q            = draw_generation();
                    inh_cause_q          = 1'b1;
                    r.granted_generation = inh_gen_q;
                    count_event(CNT_INH_GRANTS);
                    r.result_code        = log_outcome(RES_GRANTED);
                    inhibit_leases++;
                end
            end
            CMD_REL_INHIBIT:
            begin
                if (inh_gen_q == '0)
                    r.result_code = log_outcome(RES_NOT_HELD);
                else if (it.lease_generation != inh_gen_q)
                    r.result_code = log_outcome(RES_STALE);
                else
                begin
                    inh_gen_q     = '0;
                    inh_cause_q   = 1'b0;
                    r.result_code = log_outcome(RES_RELEASED);
                end
            end
            CMD_CLR_INHIBIT:
            begin
                if (inh_gen_q != '0)
                begin
                    inh_gen_q   = '0;
                    inh_cause_q = 1'b0;
                    count_event(CNT_FORCE);
                end
            end
            CMD_READ_COUNTER:
                r.counter_value = tally_q[it.counter_index];
            default:
            begin
            end
        endcase
        r.current_owner  = owner_q;
        r.inhibit_active = (inh_gen_q != '0);
        r.inhibit_cause  = inh_cause_q;
        r.last_clear     = clear_q;
        r.last_outcome   = outcome_q;
        return r;
    endfunction

    function automatic item_t make_cmd(logic [3:0] cmd, logic [2:0] owner = 3'd0,
                                       logic run_mode = 1'b0, logic [2:0] lowner = 3'd0,
                                       logic [31:0] lgen = 32'd0, logic [2:0] reason = 3'd0,
                                       logic [2:0] idx = 3'd0);
        item_t it;
        it = '0;
        it.command          = cmd;
        it.owner_code       = owner;
        it.mode             = run_mode;
        it.lease_owner      = lowner;
        it.lease_generation = lgen;
        it.reason_code      = reason;
        it.counter_index    = idx;
        return it;
    endfunction

    // mostly well-formed traffic built from the current state, with noise mixed in
    function automatic item_t random_command();
        item_t it;
        int    pick;
        it = '0;
        it.owner_code       = 3'($urandom_range(0, 7));
        it.mode             = 1'($urandom_range(0, 1));
        it.lease_owner      = 3'($urandom_range(0, 7));
        it.lease_generation = $urandom();
        it.reason_code      = 3'($urandom_range(0, 7));
        it.counter_index    = 3'($urandom_range(0, 7));
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            it.command = CMD_REQUEST;
            if ($urandom_range(0, 9) < 8)
            begin
                it.owner_code = 3'($urandom_range(1, 5));
                it.mode       = (it.owner_code == MOTION_OWNER);
            end
        end
        else if (pick < 52)
        begin
            it.command = CMD_RELEASE;
            if ($urandom_range(0, 9) < 8)
            begin
                it.lease_owner      = owner_q;
                it.lease_generation = gen_q;
            end
            else if ($urandom_range(0, 1) == 0)
            begin
                it.lease_owner      = owner_q;
                it.lease_generation = gen_q ^ (32'd1 << $urandom_range(0, 31));
            end
        end
        else if (pick < 57)
            it.command = CMD_FORCE_CLEAR;
        else if (pick < 65)
            it.command = CMD_MODE_CHANGE;
        else if (pick < 73)
        begin
            it.command = CMD_REQ_INHIBIT;
            if ($urandom_range(0, 9) < 8)
                it.reason_code = INHIBIT_FW_UPDATE;
        end
        else if (pick < 81)
        begin
            it.command = CMD_REL_INHIBIT;
            if ($urandom_range(0, 9) < 8)
                it.lease_generation = inh_gen_q;
        end
        else if (pick < 84)
            it.command = CMD_CLR_INHIBIT;
        else if (pick < 95)
            it.command = CMD_READ_COUNTER;
        else if (pick < 96)
            it.command = CMD_RESET;
        else
            it.command = 4'($urandom_range(9, 15));
        return it;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("mismatch at result %0d, %s: got 0x%0h, expected 0x%0h",
                     results_checked, what, got, want);
    endtask

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_command(input item_t it);
        if (with_idle && $urandom_range(0, 99) < 15)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        s_tdata  <= it;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        verdict_q.push_back(arbitrate_command(it));
        commands_sent++;
        @(negedge clk);
    endtask

    task automatic test_request_checks();
        send_command(make_cmd(CMD_REQUEST, OWNER_NONE));
        send_command(make_cmd(CMD_REQUEST, 3'd7, 1'b1));
        send_command(make_cmd(CMD_REQUEST, MOTION_OWNER, MODE_MAINT));
        send_command(make_cmd(CMD_REQUEST, 3'd1, MODE_MAINT));
        send_command(make_cmd(CMD_REQUEST, 3'd1, MODE_MAINT));
        send_command(make_cmd(CMD_REQUEST, 3'd2, MODE_MAINT));
    endtask

    task automatic test_release_checks();
        send_command(make_cmd(CMD_RELEASE, 3'd0, 1'b0, 3'd2, gen_q));
        send_command(make_cmd(CMD_RELEASE, 3'd0, 1'b0, 3'd1, 32'hFFFF_FFFE));
        send_command(make_cmd(CMD_RELEASE, 3'd0, 1'b0, 3'd1, gen_q));
        send_command(make_cmd(CMD_RELEASE, 3'd0, 1'b0, 3'd1, gen_q));
    endtask

    task automatic test_inhibit();
        send_command(make_cmd(CMD_REQ_INHIBIT, 3'd0, 1'b0, 3'd0, 32'd0, 3'd0));
        send_command(make_cmd(CMD_REQ_INHIBIT, 3'd0, 1'b0, 3'd0, 32'd0, 3'd7));
        send_command(make_cmd(CMD_REQUEST, 3'd3, MODE_MAINT));
        send_command(make_cmd(CMD_REQ_INHIBIT, 3'd0, 1'b0, 3'd0, 32'd0, INHIBIT_FW_UPDATE));
        send_command(make_cmd(CMD_FORCE_CLEAR, 3'd0, 1'b0, 3'd0, 32'd0, 3'd4));
        send_command(make_cmd(CMD_REQ_INHIBIT, 3'd0, 1'b0, 3'd0, 32'd0, INHIBIT_FW_UPDATE));
        send_command(make_cmd(CMD_REQUEST, 3'd2, MODE_MAINT));
        send_command(make_cmd(CMD_REL_INHIBIT, 3'd0, 1'b0, 3'd0, 32'd0));
        send_command(make_cmd(CMD_REL_INHIBIT, 3'd0, 1'b0, 3'd0, inh_gen_q));
        send_command(make_cmd(CMD_REQ_INHIBIT, 3'd0, 1'b0, 3'd0, 32'd0, INHIBIT_FW_UPDATE));
        send_command(make_cmd(CMD_CLR_INHIBIT));
        send_command(make_cmd(CMD_CLR_INHIBIT));
    endtask

    task automatic test_mode_and_clear();
        send_command(make_cmd(CMD_REQUEST, MOTION_OWNER, 1'b1));
        send_command(make_cmd(CMD_MODE_CHANGE, 3'd0, 1'b1));
        send_command(make_cmd(CMD_MODE_CHANGE, 3'd0, MODE_MAINT));
        send_command(make_cmd(CMD_FORCE_CLEAR, 3'd0, 1'b0, 3'd0, 32'd0, 3'd7));
    endtask

    task automatic test_counters_and_reset();
        send_command(make_cmd(4'd15, 3'd7, 1'b1, 3'd7, 32'hFFFF_FFFF, 3'd7, 3'd7));
        send_command(make_cmd(CMD_READ_COUNTER, 3'd0, 1'b0, 3'd0, 32'd0, 3'd0, CNT_REJECTIONS));
        send_command(make_cmd(CMD_READ_COUNTER, 3'd0, 1'b0, 3'd0, 32'd0, 3'd0, CNT_INH_GRANTS));
        send_command(make_cmd(CMD_RESET, 3'd0, 1'b0, 3'd0, 32'd0, 3'd6));
        send_command(make_cmd(CMD_READ_COUNTER, 3'd0, 1'b0, 3'd0, 32'd0, 3'd0, CNT_REJECTIONS));
    endtask

    task automatic test_random_traffic(input int count, input bit bursty);
        for (int i = 0; i < count; i++)
        begin
            // leave calm stretches between the bursty ones
            with_idle = bursty && ((i % 120) >= 30);
            send_command(random_command());
        end
    endtask

    // result side: random stall bursts, released at a falling edge
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (with_idle && $urandom_range(0, 99) < 15)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            results_checked++;
            if (verdict_q.size() == 0)
                report_mismatch("result with nothing pending", 32'(got.result_code), 32'd0);
            else
            begin
                want = verdict_q.pop_front();
                if (got.result_code !== want.result_code)
                    report_mismatch("result_code", 32'(got.result_code),
                                    32'(want.result_code));
                if (got.granted_owner !== want.granted_owner)
                    report_mismatch("granted_owner", 32'(got.granted_owner),
                                    32'(want.granted_owner));
                if (got.granted_generation !== want.granted_generation)
                    report_mismatch("granted_generation", got.granted_generation,
                                    want.granted_generation);
                if (got.current_owner !== want.current_owner)
                    report_mismatch("current_owner", 32'(got.current_owner),
                                    32'(want.current_owner));
                if (got.inhibit_active !== want.inhibit_active)
                    report_mismatch("inhibit_active", 32'(got.inhibit_active),
                                    32'(want.inhibit_active));
                if (got.inhibit_cause !== want.inhibit_cause)
                    report_mismatch("inhibit_cause", 32'(got.inhibit_cause),
                                    32'(want.inhibit_cause));
                if (got.last_clear !== want.last_clear)
                    report_mismatch("last_clear", 32'(got.last_clear), 32'(want.last_clear));
                if (got.last_outcome !== want.last_outcome)
                    report_mismatch("last_outcome", 32'(got.last_outcome),
                                    32'(want.last_outcome));
                if (got.counter_value !== want.counter_value)
                    report_mismatch("counter_value", got.counter_value, want.counter_value);
                if (got.pad !== want.pad)
                    report_mismatch("pad", 32'(got.pad), 32'(want.pad));
            end
        end
    end

    // end the run when no transfer happens on either side for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no transfer for %0d cycles, %0d results still pending",
                 QUIET_LIMIT, verdict_q.size());
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        rst_n           = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        with_idle       = 1'b1;
        commands_sent   = 0;
        results_checked = 0;
        mismatches      = 0;
        lease_grants    = 0;
        inhibit_leases  = 0;
        clear_state();
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_request_checks();
        test_release_checks();
        test_inhibit();
        test_mode_and_clear();
        test_counters_and_reset();
        test_random_traffic(850, 1'b1);
        test_random_traffic(200, 1'b0);

        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("covered %0d commands: %0d lease grants, %0d inhibit grants",
                 commands_sent, lease_grants, inhibit_leases);
        $display("compared %0d results, %0d field mismatches", results_checked, mismatches);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> files.f
rtl/core/lla_pkg.sv
rtl/core/lla_in_stage.sv
rtl/core/lla_engine.sv
rtl/core/lla_out_stage.sv
rtl/core/lease_lock_arbiter_core.sv
tb/testbench.sv
